/* rtl/sdtf_pkg.sv */
// ----------------------------------------------------------------------------
// sdtf_pkg
// Shared types and constants for the sky dome texture coordinate fan.
// ----------------------------------------------------------------------------
package sdtf_pkg;

	localparam int POS_W   = 24;
	localparam int TEX_W   = 16;
	localparam int SCR_W   = 12;
	localparam int DX_W    = POS_W + 1;
	localparam int DZ3_W   = POS_W + 3;
	localparam int SUM_W   = 52;
	localparam int RAD_W   = SUM_W + 8;
	localparam int LS_W    = RAD_W / 2;
	localparam int GAIN_W  = 18;
	localparam int NUM_W   = POS_W + GAIN_W;
	localparam int QUO_W   = 14;
	localparam int DSH_W   = LS_W + QUO_W - 1;
	localparam int CFG_W   = 32;
	localparam int IDX_W   = 3;

	// Offset gain: sky radius 378 scaled to Q9.9 over a Q.4 length
	localparam logic [GAIN_W-1:0] OFFSET_GAIN = GAIN_W'(193536);

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_VIEW_X      = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_VIEW_Y      = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_VIEW_Z      = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_SCROLL_TIME = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_SKY_LAYER   = IDX_W'(4);

	// Fan assembly: vertices held so far and triangle beat
	localparam logic [1:0] CNT_EMPTY = 2'd0;
	localparam logic [1:0] CNT_FIRST = 2'd1;
	localparam logic [1:0] CNT_FAN   = 2'd2;
	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_PREV   = 2'd1;
	localparam logic [1:0] PH_CUR    = 2'd2;

	typedef enum logic [2:0] {
		F_IDLE,
		F_SQUARE,
		F_SUM,
		F_ROOT,
		F_PREP,
		F_DIV,
		F_PUSH
	} front_state_t;

	// One processed vertex
	typedef struct packed {
		logic              eop;
		logic              zflag;
		logic [TEX_W-1:0]  tex_t;
		logic [TEX_W-1:0]  tex_s;
		logic [POS_W-1:0]  pos_z;
		logic [POS_W-1:0]  pos_y;
		logic [POS_W-1:0]  pos_x;
	} vtx_t;

	// View and scroll settings handed to the front
	typedef struct packed {
		logic signed [POS_W-1:0] view_x;
		logic signed [POS_W-1:0] view_y;
		logic signed [POS_W-1:0] view_z;
		logic [CFG_W-1:0]        scroll_time;
		logic                    sky_layer;
	} cfg_t;

endpackage

/* rtl/sdtf_front.sv */
// ----------------------------------------------------------------------------
// sdtf_front
// Accepts a vertex, projects it onto the dome and works out its texture
// coordinates with an iterative square root and a shared-step divider.
// ----------------------------------------------------------------------------
module sdtf_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [3*sdtf_pkg::POS_W-1:0]  s_tdata,
	input  logic                          s_tlast,
	input  sdtf_pkg::cfg_t                cfg,
	output logic                          push_valid,
	input  logic                          push_ready,
	output sdtf_pkg::vtx_t                push_item
);

	sdtf_pkg::front_state_t state_q, state_n;

	logic [sdtf_pkg::POS_W-1:0]        px_q, py_q, pz_q;
	logic                              eop_q;
	logic [sdtf_pkg::SCR_W-1:0]        scroll_q;
	logic signed [sdtf_pkg::DX_W-1:0]  dx_q, dy_q;
	logic signed [sdtf_pkg::DZ3_W-1:0] dz_q;
	logic [sdtf_pkg::SUM_W-1:0]        sqx_q, sqy_q, sqz_q;
	logic [sdtf_pkg::RAD_W-1:0]        rem_q, res_q, bit_q;
	logic                              zero_q;
	logic [sdtf_pkg::NUM_W-1:0]        mulx_q, muly_q, nx_q, ny_q;
	logic [sdtf_pkg::DSH_W-1:0]        dsh_q;
	logic [sdtf_pkg::QUO_W-1:0]        qx_q, qy_q;
	logic [3:0]                        cnt_q;

	logic signed [sdtf_pkg::DX_W-1:0]  dx_in, dy_in, dz_in;
	logic [sdtf_pkg::POS_W-1:0]        magx, magy;
	logic [sdtf_pkg::RAD_W-1:0]        trial;
	logic [sdtf_pkg::DSH_W-1:0]        nx_ext, ny_ext;
	logic                              gex, gey;
	logic [sdtf_pkg::LS_W-1:0]         ls;
	logic [sdtf_pkg::TEX_W-1:0]        offx, offy;

	// Differences against the view origin
	assign dx_in = $signed({s_tdata[23], s_tdata[23:0]}) - $signed({cfg.view_x[23], cfg.view_x});
	assign dy_in = $signed({s_tdata[47], s_tdata[47:24]}) - $signed({cfg.view_y[23], cfg.view_y});
	assign dz_in = $signed({s_tdata[71], s_tdata[71:48]}) - $signed({cfg.view_z[23], cfg.view_z});

	assign magx  = dx_q[sdtf_pkg::DX_W-1] ? sdtf_pkg::POS_W'(-dx_q) : sdtf_pkg::POS_W'(dx_q);
	assign magy  = dy_q[sdtf_pkg::DX_W-1] ? sdtf_pkg::POS_W'(-dy_q) : sdtf_pkg::POS_W'(dy_q);
	assign trial = res_q + bit_q;
	assign nx_ext = sdtf_pkg::DSH_W'(nx_q);
	assign ny_ext = sdtf_pkg::DSH_W'(ny_q);
	assign gex   = nx_ext >= dsh_q;
	assign gey   = ny_ext >= dsh_q;
	assign ls    = res_q[sdtf_pkg::LS_W-1:0];

	// Next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			sdtf_pkg::F_IDLE:   if (s_tvalid) state_n = sdtf_pkg::F_SQUARE;
			sdtf_pkg::F_SQUARE: state_n = sdtf_pkg::F_SUM;
			sdtf_pkg::F_SUM: begin
				state_n = ((sqx_q + sqy_q + sqz_q) == '0) ? sdtf_pkg::F_PUSH : sdtf_pkg::F_ROOT;
			end
			sdtf_pkg::F_ROOT:   if (bit_q[0]) state_n = sdtf_pkg::F_PREP;
			sdtf_pkg::F_PREP:   state_n = sdtf_pkg::F_DIV;
			sdtf_pkg::F_DIV:    if (cnt_q == '0) state_n = sdtf_pkg::F_PUSH;
			sdtf_pkg::F_PUSH:   if (push_ready) state_n = sdtf_pkg::F_IDLE;
			default:            state_n = sdtf_pkg::F_IDLE;
		endcase
	end

	// Handshake outputs
	always_comb begin
		s_tready   = 1'b0;
		push_valid = 1'b0;
		unique case (state_q)
			sdtf_pkg::F_IDLE: s_tready   = 1'b1;
			sdtf_pkg::F_PUSH: push_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sdtf_pkg::F_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Datapath: latch, square, sum, root, divide
	always_ff @(posedge clk) begin
		unique case (state_q)
			sdtf_pkg::F_IDLE: begin
				px_q     <= s_tdata[23:0];
				py_q     <= s_tdata[47:24];
				pz_q     <= s_tdata[71:48];
				eop_q    <= s_tlast;
				dx_q     <= dx_in;
				dy_q     <= dy_in;
				dz_q     <= sdtf_pkg::DZ3_W'(dz_in) + (sdtf_pkg::DZ3_W'(dz_in) <<< 1);
				scroll_q <= cfg.sky_layer ? cfg.scroll_time[18:7] : cfg.scroll_time[19:8];
			end
			sdtf_pkg::F_SQUARE: begin
				sqx_q <= sdtf_pkg::SUM_W'(dx_q * dx_q);
				sqy_q <= sdtf_pkg::SUM_W'(dy_q * dy_q);
				sqz_q <= sdtf_pkg::SUM_W'(dz_q * dz_q);
			end
			sdtf_pkg::F_SUM: begin
				rem_q  <= {sqx_q + sqy_q + sqz_q, 8'b0};
				res_q  <= '0;
				bit_q  <= sdtf_pkg::RAD_W'(1) << (sdtf_pkg::RAD_W - 2);
				zero_q <= (sqx_q + sqy_q + sqz_q) == '0;
				mulx_q <= sdtf_pkg::NUM_W'(magx * sdtf_pkg::OFFSET_GAIN);
				muly_q <= sdtf_pkg::NUM_W'(magy * sdtf_pkg::OFFSET_GAIN);
			end
			sdtf_pkg::F_ROOT: begin
				if (rem_q >= trial) begin
					rem_q <= rem_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			sdtf_pkg::F_PREP: begin
				nx_q  <= mulx_q + sdtf_pkg::NUM_W'(ls >> 1);
				ny_q  <= muly_q + sdtf_pkg::NUM_W'(ls >> 1);
				dsh_q <= {ls, {(sdtf_pkg::QUO_W-1){1'b0}}};
				cnt_q <= 4'(sdtf_pkg::QUO_W - 1);
				qx_q  <= '0;
				qy_q  <= '0;
			end
			sdtf_pkg::F_DIV: begin
				if (gex) nx_q <= sdtf_pkg::NUM_W'(nx_ext - dsh_q);
				if (gey) ny_q <= sdtf_pkg::NUM_W'(ny_ext - dsh_q);
				qx_q  <= {qx_q[sdtf_pkg::QUO_W-2:0], gex};
				qy_q  <= {qy_q[sdtf_pkg::QUO_W-2:0], gey};
				dsh_q <= dsh_q >> 1;
				cnt_q <= cnt_q - 4'd1;
			end
			default: ;
		endcase
	end

	// Signed offsets, dropped at zero distance
	always_comb begin
		offx = '0;
		offy = '0;
		if (!zero_q) begin
			offx = dx_q[sdtf_pkg::DX_W-1] ? -sdtf_pkg::TEX_W'(qx_q) : sdtf_pkg::TEX_W'(qx_q);
			offy = dy_q[sdtf_pkg::DX_W-1] ? -sdtf_pkg::TEX_W'(qy_q) : sdtf_pkg::TEX_W'(qy_q);
		end
	end

	assign push_item.pos_x = px_q;
	assign push_item.pos_y = py_q;
	assign push_item.pos_z = pz_q;
	assign push_item.tex_s = sdtf_pkg::TEX_W'(scroll_q) + offx;
	assign push_item.tex_t = sdtf_pkg::TEX_W'(scroll_q) + offy;
	assign push_item.zflag = zero_q;
	assign push_item.eop   = eop_q;

endmodule

/* rtl/sdtf_queue.sv */
// ----------------------------------------------------------------------------
// sdtf_queue
// Two-entry queue of processed vertices between the front and the fan back.
// ----------------------------------------------------------------------------
module sdtf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  sdtf_pkg::vtx_t push_item,
	output logic           head_valid,
	input  logic           pop,
	output sdtf_pkg::vtx_t head
);

	sdtf_pkg::vtx_t mem_q [2];
	logic           wr_q, rd_q;
	logic [1:0]     fill_q;
	logic           do_push, do_pop;

	assign push_ready = fill_q != 2'd2;
	assign head_valid = fill_q != 2'd0;
	assign head       = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	// Store entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop)  rd_q <= !rd_q;
			fill_q <= fill_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

/* rtl/sdtf_back.sv */
// ----------------------------------------------------------------------------
// sdtf_back
// Fan assembly: holds the first and previous vertex of a polygon and emits
// one triangle per further vertex through an output register.
// ----------------------------------------------------------------------------
module sdtf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  sdtf_pkg::vtx_t head,
	output logic           pop,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [103:0]   m_tdata,
	output logic           m_tlast,
	output logic           m_tuser
);

	sdtf_pkg::vtx_t first_q, prev_q, sel;
	logic [1:0]     cnt_q, ph_q;
	logic           m_tvalid_q, load, out_free;
	logic [103:0]   m_tdata_q;
	logic           m_tlast_q, m_tuser_q;

	assign out_free = !m_tvalid_q || m_tready;

	// Pick the beat of the triangle
	always_comb begin
		unique case (ph_q)
			sdtf_pkg::PH_FIRST: sel = first_q;
			sdtf_pkg::PH_PREV:  sel = prev_q;
			default:            sel = head;
		endcase
	end

	// Decide load and pop
	always_comb begin
		pop  = 1'b0;
		load = 1'b0;
		if (head_valid) begin
			if (cnt_q != sdtf_pkg::CNT_FAN) begin
				pop = 1'b1;
			end else if (out_free) begin
				load = 1'b1;
				pop  = ph_q == sdtf_pkg::PH_CUR;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			cnt_q      <= sdtf_pkg::CNT_EMPTY;
			ph_q       <= sdtf_pkg::PH_FIRST;
		end else begin
			m_tvalid_q <= load || (m_tvalid_q && !m_tready);
			if (load) begin
				ph_q <= (ph_q == sdtf_pkg::PH_CUR) ? sdtf_pkg::PH_FIRST : ph_q + 2'd1;
			end
			if (pop) begin
				if (head.eop)                         cnt_q <= sdtf_pkg::CNT_EMPTY;
				else if (cnt_q != sdtf_pkg::CNT_FAN) cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	// Hold polygon vertices and the output beat
	always_ff @(posedge clk) begin
		if (pop) begin
			if (cnt_q == sdtf_pkg::CNT_EMPTY) first_q <= head;
			else                              prev_q  <= head;
		end
		if (load) begin
			m_tdata_q <= {sel.tex_t, sel.tex_s, sel.pos_z, sel.pos_y, sel.pos_x};
			m_tlast_q <= ph_q == sdtf_pkg::PH_CUR;
			m_tuser_q <= sel.zflag;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

endmodule

/* rtl/sky_dome_texcoord_fan_top.sv */
// ----------------------------------------------------------------------------
// sky_dome_texcoord_fan_top
// Sky dome texture projection with triangle fan assembly.
// ----------------------------------------------------------------------------
// One vertex is taken at a time. A vertex passes the square, sum, bit-pair
// square root, prep and restoring divider states (both offsets divided side by
// side) before it is pushed to the queue, and the next vertex is taken only
// once the queue has accepted it. A vertex at the view origin skips the root
// and the divider. The back emits three beats per triangle from the third
// vertex of a polygon on, and a two-entry queue lets it drain while the front
// works on the next vertex.
module sky_dome_texcoord_fan_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [71:0]  s_tdata,   // pos_x, pos_y, pos_z
	input  logic         s_tlast,   // end_of_polygon
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,   // out_x, out_y, out_z, tex_s, tex_t
	output logic         m_tlast,   // triangle_last
	output logic         m_tuser,   // zero_distance
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	sdtf_pkg::cfg_t cfg_q;
	sdtf_pkg::vtx_t push_item, head;
	logic           push_valid, push_ready, head_valid, pop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sdtf_pkg::REG_VIEW_X:      cfg_q.view_x      <= cfg_data[23:0];
				sdtf_pkg::REG_VIEW_Y:      cfg_q.view_y      <= cfg_data[23:0];
				sdtf_pkg::REG_VIEW_Z:      cfg_q.view_z      <= cfg_data[23:0];
				sdtf_pkg::REG_SCROLL_TIME: cfg_q.scroll_time <= cfg_data;
				sdtf_pkg::REG_SKY_LAYER:   cfg_q.sky_layer   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	sdtf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.cfg        (cfg_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	sdtf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.head_valid (head_valid),
		.pop        (pop),
		.head       (head)
	);

	sdtf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule

/* rtl/sdtf_checker.sv */
// ----------------------------------------------------------------------------
// sdtf_checker
// Port-level checks for the sky dome fan, bound to the top level.
// ----------------------------------------------------------------------------
module sdtf_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [103:0] m_tdata,
	input logic         m_tlast
);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output beat changed under stall");

	// Front is busy right after a transfer in
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second vertex taken while one is in work");

	// Triangle beats follow one another without gaps
	a_triangle_burst: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("gap inside a triangle");

	// Nothing leaves straight after reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("output valid after reset");

endmodule

bind sky_dome_texcoord_fan_top sdtf_checker u_sdtf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
